// ===== sv/ipsb_pkg.sv =====
// types, constants and helper functions of the indexed pixel scaled blitter
// no dependencies; imported by every module of the block
package ipsb_pkg;

	localparam int COORD_BITS = 10;
	localparam int SCALE_W = 4;
	localparam int DIM_W = 11;
	localparam int BOUND_W = COORD_BITS + 1;
	localparam int POS_W = COORD_BITS + SCALE_W + 1;
	localparam int COLOR_W = 16;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [SCALE_W-1:0] MAX_SCALE = 4'd8;
	localparam logic [BOUND_W-1:0] BOUND_MAX = {1'b1, {COORD_BITS{1'b0}}};

	localparam logic CMD_PAL = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	typedef enum logic [2:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_OFFSET_X,
		REG_OFFSET_Y,
		REG_SCALE_X,
		REG_SCALE_Y,
		REG_SWAP
	} reg_idx_t;

	typedef struct packed {
		logic                  cmd;
		logic [7:0]            pal_addr;
		logic [COLOR_W-1:0]    pal_color;
		logic [7:0]            pixel_index;
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic                  has_transparency;
		logic [7:0]            transparent_index;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] dst_x;
		logic [COORD_BITS-1:0] dst_y;
		logic [COLOR_W-1:0]    color;
		logic                  last;
	} out_item_t;

	typedef struct packed {
		logic [DIM_W-1:0]      width_px;
		logic [DIM_W-1:0]      height_px;
		logic [COORD_BITS-1:0] offset_x;
		logic [COORD_BITS-1:0] offset_y;
		logic [SCALE_W-1:0]    scale_x;
		logic [SCALE_W-1:0]    scale_y;
		logic                  byte_swap;
	} cfg_t;

	// one visible block, already clipped to the canvas
	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [SCALE_W-1:0]    ncols;
		logic [SCALE_W-1:0]    nrows;
		logic [COLOR_W-1:0]    color;
	} job_t;

	function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
		logic [SCALE_W-1:0] r;
		if (s == '0) begin
			r = SCALE_W'(1);
		end else if (s > MAX_SCALE) begin
			r = MAX_SCALE;
		end else begin
			r = s;
		end
		return r;
	endfunction

	function automatic logic [BOUND_W-1:0] eff_bound(input logic [DIM_W-1:0] b);
		logic [BOUND_W-1:0] r;
		if (BOUND_W'(b) > BOUND_MAX) begin
			r = BOUND_MAX;
		end else begin
			r = BOUND_W'(b);
		end
		return r;
	endfunction

endpackage

// ===== sv/ipsb_regs.sv =====
// configuration register file with an apb-style access port
// depends on ipsb_pkg for the register map and cfg_t
module ipsb_regs import ipsb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_px <= DIM_W'(128);
			cfg_q.height_px <= DIM_W'(128);
			cfg_q.offset_x <= '0;
			cfg_q.offset_y <= '0;
			cfg_q.scale_x <= SCALE_W'(1);
			cfg_q.scale_y <= SCALE_W'(1);
			cfg_q.byte_swap <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_WIDTH:    cfg_q.width_px <= pwdata[DIM_W-1:0];
				REG_HEIGHT:   cfg_q.height_px <= pwdata[DIM_W-1:0];
				REG_OFFSET_X: cfg_q.offset_x <= pwdata[COORD_BITS-1:0];
				REG_OFFSET_Y: cfg_q.offset_y <= pwdata[COORD_BITS-1:0];
				REG_SCALE_X:  cfg_q.scale_x <= pwdata[SCALE_W-1:0];
				REG_SCALE_Y:  cfg_q.scale_y <= pwdata[SCALE_W-1:0];
				REG_SWAP:     cfg_q.byte_swap <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:    prdata = PDATA_W'(cfg_q.width_px);
			REG_HEIGHT:   prdata = PDATA_W'(cfg_q.height_px);
			REG_OFFSET_X: prdata = PDATA_W'(cfg_q.offset_x);
			REG_OFFSET_Y: prdata = PDATA_W'(cfg_q.offset_y);
			REG_SCALE_X:  prdata = PDATA_W'(cfg_q.scale_x);
			REG_SCALE_Y:  prdata = PDATA_W'(cfg_q.scale_y);
			REG_SWAP:     prdata = PDATA_W'(cfg_q.byte_swap);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== sv/ipsb_front.sv =====
// front end: takes requests, owns the palette, drops transparent pixels,
// places and clips each block and hands visible jobs to the queue; uses ipsb_pkg
module ipsb_front import ipsb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	output logic     q_push,
	output job_t     q_din,
	input  logic     q_full
);

	logic [COLOR_W-1:0] palette [256];

	logic               vld_s1;
	logic               keep_s1;
	logic [COLOR_W-1:0] rd_s1;
	logic [POS_W-1:0]   x0_s1;
	logic [POS_W-1:0]   y0_s1;
	logic [SCALE_W-1:0] sx_s1;
	logic [SCALE_W-1:0] sy_s1;

	logic               acc;
	logic [SCALE_W-1:0] sx;
	logic [SCALE_W-1:0] sy;
	logic [POS_W-1:0]   x0;
	logic [POS_W-1:0]   y0;
	logic [BOUND_W-1:0] bw;
	logic [BOUND_W-1:0] bh;
	logic               vis_x;
	logic               vis_y;
	logic [BOUND_W-1:0] rem_x;
	logic [BOUND_W-1:0] rem_y;
	logic               hold;

	assign sx = eff_scale(cfg.scale_x);
	assign sy = eff_scale(cfg.scale_y);
	assign x0 = POS_W'(cfg.offset_x) + POS_W'(item.src_x) * POS_W'(sx);
	assign y0 = POS_W'(cfg.offset_y) + POS_W'(item.src_y) * POS_W'(sy);

	// clip against the canvas
	assign bw = eff_bound(cfg.width_px);
	assign bh = eff_bound(cfg.height_px);
	assign vis_x = x0_s1 < POS_W'(bw);
	assign vis_y = y0_s1 < POS_W'(bh);
	assign rem_x = bw - x0_s1[BOUND_W-1:0];
	assign rem_y = bh - y0_s1[BOUND_W-1:0];

	assign q_push = vld_s1 && keep_s1 && vis_x && vis_y;
	assign hold = q_push && q_full;
	assign full = hold;
	assign acc = push && !full;

	always_comb begin
		q_din.x0 = x0_s1[COORD_BITS-1:0];
		q_din.y0 = y0_s1[COORD_BITS-1:0];
		q_din.ncols = (rem_x < BOUND_W'(sx_s1)) ? rem_x[SCALE_W-1:0] : sx_s1;
		q_din.nrows = (rem_y < BOUND_W'(sy_s1)) ? rem_y[SCALE_W-1:0] : sy_s1;
		q_din.color = cfg.byte_swap ? {rd_s1[7:0], rd_s1[15:8]} : rd_s1;
	end

	always_ff @(posedge clk) begin
		if (acc && item.cmd == CMD_PAL) begin
			palette[item.pal_addr] <= item.pal_color;
		end
		if (acc) begin
			rd_s1 <= palette[item.pixel_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!hold) begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			keep_s1 <= item.cmd == CMD_DRAW &&
				!(item.has_transparency && item.pixel_index == item.transparent_index);
			x0_s1 <= x0;
			y0_s1 <= y0;
			sx_s1 <= sx;
			sy_s1 <= sy;
		end
	end

endmodule

// ===== sv/ipsb_queue.sv =====
// short job queue between front and back end
// depends on ipsb_pkg for job_t
module ipsb_queue import ipsb_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	output logic full,
	input  logic pop,
	output job_t dout,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	job_t            slots [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = slots[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/ipsb_back.sv =====
// back end: walks each clipped block row by row and drives the result register
// depends on ipsb_pkg for job_t and out_item_t
module ipsb_back import ipsb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      q_dout,
	input  logic      q_empty,
	output logic      q_pop,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	job_t               job_q;
	logic               job_vld_q;
	logic [SCALE_W-1:0] cx_q;
	logic [SCALE_W-1:0] cy_q;
	out_item_t          out_q;
	logic               out_vld_q;

	logic               load_out;
	logic               end_col;
	logic               is_last;
	logic               take;

	assign load_out = job_vld_q && (!out_vld_q || pop);
	assign end_col = cx_q == job_q.ncols - SCALE_W'(1);
	assign is_last = end_col && cy_q == job_q.nrows - SCALE_W'(1);
	assign take = !q_empty && (!job_vld_q || (load_out && is_last));
	assign q_pop = take;
	assign result = out_q;
	assign empty = !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			cx_q <= '0;
			cy_q <= '0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (take) begin
				job_vld_q <= 1'b1;
				cx_q <= '0;
				cy_q <= '0;
			end else if (load_out) begin
				if (is_last) begin
					job_vld_q <= 1'b0;
				end
				if (end_col) begin
					cx_q <= '0;
					cy_q <= cy_q + SCALE_W'(1);
				end else begin
					cx_q <= cx_q + SCALE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= q_dout;
		end
		if (load_out) begin
			out_q.dst_x <= job_q.x0 + COORD_BITS'(cx_q);
			out_q.dst_y <= job_q.y0 + COORD_BITS'(cy_q);
			out_q.color <= job_q.color;
			out_q.last <= is_last;
		end
	end

endmodule

// ===== sv/indexed_pixel_scaled_blitter_core.sv =====
// top level of the indexed pixel scaled blitter: registers, front end, job queue, back end
// depends on ipsb_pkg, ipsb_regs, ipsb_front, ipsb_queue and ipsb_back
//
//   channel   handshake           payload
//   request   push / full         item (in_item_t)
//   result    empty / pop         result (out_item_t)
//   config    psel penable pwrite paddr pwdata / prdata pready
//
// one request enters per cycle unless full; a drawn pixel gives one result per cycle while
// pop is high for each visible cell of its block (up to 64), set by the back end's walk
// a request passes the front stage, job queue and job register to the result register
// palette writes, transparent and fully clipped pixels give no result
// reset clears control and sets registers to defaults; palette is unset
// with pop low the result and job registers fill, then the job queue, then full rises
module indexed_pixel_scaled_blitter_core import ipsb_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  in_item_t           item,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output out_item_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t cfg;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t q_din;
	job_t q_dout;

	ipsb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipsb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_push (q_push),
		.q_din  (q_din),
		.q_full (q_full)
	);

	ipsb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	ipsb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_dout  (q_dout),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

// ===== dv/tb_indexed_pixel_scaled_blitter_core.sv =====
`timescale 1ns / 1ps
// testbench for indexed_pixel_scaled_blitter_core: palette loads and pixel draws are
// predicted in the bench and every canvas write is checked field by field
// depends on ipsb_pkg and the block's rtl
module tb_indexed_pixel_scaled_blitter_core;
	import ipsb_pkg::*;

	localparam int TIMEOUT_NS = 6_000_000;
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_PRINT = 40;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	in_item_t           item;
	logic               full;
	logic               empty;
	logic               pop;
	out_item_t          result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	cfg_t               canvas_cfg;
	logic [COLOR_W-1:0] pal_shadow [256];
	bit                 pal_loaded [256];
	logic [7:0]         loaded_idx [$];
	out_item_t          pending_writes [$];

	bit calm = 1'b0;
	int hold_req = 0;
	int errors = 0;
	int n_requests = 0;
	int n_draws = 0;
	int n_checked = 0;
	int stall_cycles = 0;

	indexed_pixel_scaled_blitter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	function automatic int replicate(input logic [SCALE_W-1:0] s);
		if (s == '0) return 1;
		if (s > MAX_SCALE) return int'(MAX_SCALE);
		return int'(s);
	endfunction

	function automatic int clip_bound(input logic [DIM_W-1:0] b);
		if (int'(b) > (1 << COORD_BITS)) return 1 << COORD_BITS;
		return int'(b);
	endfunction

	// source coordinates up to this one land on the canvas, plus one past the edge
	function automatic int reach(input int off, input int s, input int b);
		int r;
		if (off >= b) return 0;
		r = (b - 1 - off) / s + 1;
		if (r > (1 << COORD_BITS) - 1) r = (1 << COORD_BITS) - 1;
		return r;
	endfunction

	task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
		errors++;
		if (errors <= MAX_PRINT)
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
	endtask

	task automatic expect_writes(input in_item_t req);
		int sx, sy, bw, bh, x0, y0, cols, rows;
		logic [COLOR_W-1:0] c;
		out_item_t w;
		n_requests++;
		if (req.cmd == CMD_PAL) begin
			pal_shadow[req.pal_addr] = req.pal_color;
			if (!pal_loaded[req.pal_addr]) begin
				pal_loaded[req.pal_addr] = 1'b1;
				loaded_idx.push_back(req.pal_addr);
			end
		end else begin
			n_draws++;
			if (!(req.has_transparency && req.pixel_index == req.transparent_index)) begin
				c = pal_shadow[req.pixel_index];
				if (canvas_cfg.byte_swap)
					c = {c[7:0], c[15:8]};
				sx = replicate(canvas_cfg.scale_x);
				sy = replicate(canvas_cfg.scale_y);
				bw = clip_bound(canvas_cfg.width_px);
				bh = clip_bound(canvas_cfg.height_px);
				x0 = int'(canvas_cfg.offset_x) + int'(req.src_x) * sx;
				y0 = int'(canvas_cfg.offset_y) + int'(req.src_y) * sy;
				cols = (x0 >= bw) ? 0 : ((bw - x0 < sx) ? bw - x0 : sx);
				rows = (y0 >= bh) ? 0 : ((bh - y0 < sy) ? bh - y0 : sy);
				for (int dy = 0; dy < rows; dy++) begin
					for (int dx = 0; dx < cols; dx++) begin
						w.dst_x = COORD_BITS'(x0 + dx);
						w.dst_y = COORD_BITS'(y0 + dy);
						w.color = c;
						w.last = (dy == rows - 1) && (dx == cols - 1);
						pending_writes.push_back(w);
					end
				end
			end
		end
	endtask

	task automatic send_request(input in_item_t req);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full) @(posedge clk);
		expect_writes(req);
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input reg_idx_t r, input logic [PDATA_W-1:0] v);
		logic [PDATA_W-1:0] want;
		want = '0;
		case (r)
			REG_WIDTH: begin
				canvas_cfg.width_px = v[DIM_W-1:0];
				want = PDATA_W'(v[DIM_W-1:0]);
			end
			REG_HEIGHT: begin
				canvas_cfg.height_px = v[DIM_W-1:0];
				want = PDATA_W'(v[DIM_W-1:0]);
			end
			REG_OFFSET_X: begin
				canvas_cfg.offset_x = v[COORD_BITS-1:0];
				want = PDATA_W'(v[COORD_BITS-1:0]);
			end
			REG_OFFSET_Y: begin
				canvas_cfg.offset_y = v[COORD_BITS-1:0];
				want = PDATA_W'(v[COORD_BITS-1:0]);
			end
			REG_SCALE_X: begin
				canvas_cfg.scale_x = v[SCALE_W-1:0];
				want = PDATA_W'(v[SCALE_W-1:0]);
			end
			REG_SCALE_Y: begin
				canvas_cfg.scale_y = v[SCALE_W-1:0];
				want = PDATA_W'(v[SCALE_W-1:0]);
			end
			REG_SWAP: begin
				canvas_cfg.byte_swap = v[0];
				want = PDATA_W'(v[0]);
			end
			default: want = '0;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({r, 2'b00});
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// read back from the same register
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			flag_field($sformatf("register %s readback", r.name()), want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int w, h, ox, oy, sx, sy, sw);
		settle();
		program_reg(REG_WIDTH, PDATA_W'(w));
		program_reg(REG_HEIGHT, PDATA_W'(h));
		program_reg(REG_OFFSET_X, PDATA_W'(ox));
		program_reg(REG_OFFSET_Y, PDATA_W'(oy));
		program_reg(REG_SCALE_X, PDATA_W'(sx));
		program_reg(REG_SCALE_Y, PDATA_W'(sy));
		program_reg(REG_SWAP, PDATA_W'(sw));
	endtask

	task automatic load_entry(input logic [7:0] addr, input logic [COLOR_W-1:0] c);
		in_item_t req;
		req = '0;
		req.cmd = CMD_PAL;
		req.pal_addr = addr;
		req.pal_color = c;
		send_request(req);
	endtask

	task automatic draw_pixel(input logic [7:0] idx, input int x, input int y,
			input bit has_t, input logic [7:0] t_idx);
		in_item_t req;
		req = '0;
		req.cmd = CMD_DRAW;
		req.pixel_index = idx;
		req.src_x = COORD_BITS'(x);
		req.src_y = COORD_BITS'(y);
		req.has_transparency = has_t;
		req.transparent_index = t_idx;
		send_request(req);
	endtask

	// draws mostly land on the canvas, some anywhere; indexes only from loaded entries
	function automatic in_item_t random_request(input bit draw);
		logic [63:0] raw;
		in_item_t req;
		int lim;
		raw = {$urandom, $urandom};
		req = raw[$bits(in_item_t)-1:0];
		req.cmd = draw ? CMD_DRAW : CMD_PAL;
		if (draw) begin
			req.pixel_index = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
			if ($urandom_range(0, 3) == 0)
				req.transparent_index = req.pixel_index;
			if ($urandom_range(0, 5) != 0) begin
				lim = reach(int'(canvas_cfg.offset_x), replicate(canvas_cfg.scale_x),
					clip_bound(canvas_cfg.width_px));
				req.src_x = COORD_BITS'($urandom_range(0, lim));
				lim = reach(int'(canvas_cfg.offset_y), replicate(canvas_cfg.scale_y),
					clip_bound(canvas_cfg.height_px));
				req.src_y = COORD_BITS'($urandom_range(0, lim));
			end
		end
		return req;
	endfunction

	task automatic run_stream(input int count);
		for (int i = 0; i < count; i++)
			send_request(random_request($urandom_range(0, 4) != 0));
	endtask

	task automatic test_palette_and_clipping();
		load_entry(8'h00, 16'hF81F);
		load_entry(8'hFF, 16'h07E0);
		load_entry(8'hA5, 16'hFFFF);
		load_entry(8'h5A, 16'h0000);
		load_entry(8'h01, 16'h1234);
		draw_pixel(8'h00, 0, 0, 1'b0, 8'h00);
		draw_pixel(8'hFF, 127, 127, 1'b0, 8'h00);
		draw_pixel(8'hA5, 128, 5, 1'b0, 8'h00);
		draw_pixel(8'h5A, 3, 1023, 1'b0, 8'h00);
		draw_pixel(8'h01, 1023, 1023, 1'b0, 8'h00);
		draw_pixel(8'hA5, 5, 6, 1'b1, 8'hA5);
		draw_pixel(8'h01, 7, 8, 1'b1, 8'hFE);
		draw_pixel(8'h5A, 9, 9, 1'b0, 8'h5A);
		load_entry(8'h01, 16'hABCD);
		draw_pixel(8'h01, 10, 10, 1'b0, 8'h00);
		draw_pixel(8'hFF, 0, 127, 1'b1, 8'hFF);
	endtask

	task automatic test_config_extremes();
		// oversized canvas, saturating and zero scale, byte swap, offsets at the far edge
		configure(2047, 2047, 1023, 1023, 15, 0, 1);
		draw_pixel(8'hA5, 0, 0, 1'b0, 8'h00);
		draw_pixel(8'h01, 1, 0, 1'b0, 8'h00);
		// zero width canvas
		configure(0, 5, 0, 0, 2, 2, 0);
		draw_pixel(8'h00, 0, 0, 1'b0, 8'h00);
		// full 8x8 block, then one cut by both edges
		configure(16, 16, 3, 2, 8, 8, 1);
		draw_pixel(8'hFF, 0, 0, 1'b0, 8'h00);
		draw_pixel(8'h01, 1, 1, 1'b0, 8'h00);
	endtask

	task automatic test_random_settings();
		configure(128, 128, 0, 0, 1, 1, 0);
		run_stream(70);
		configure(2047, 2047, 0, 0, 15, 8, 1);
		run_stream(50);
		configure(1024, 1024, 1023, 1023, 0, 3, 0);
		run_stream(50);
		configure(1, 1024, 0, 517, 8, 1, 1);
		run_stream(50);
		configure(700, 0, 12, 0, 2, 2, 1);
		run_stream(20);
		repeat (2) begin
			configure($urandom_range(1, 1100), $urandom_range(1, 1100), $urandom_range(0, 300),
				$urandom_range(0, 300), $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 1));
			run_stream(60);
		end
	endtask

	task automatic test_result_backpressure();
		in_item_t req;
		configure(128, 128, 0, 0, 4, 4, 0);
		hold_req = 400;
		for (int i = 0; i < 40; i++) begin
			req = random_request(1'b1);
			req.has_transparency = 1'b0;
			req.src_x = COORD_BITS'($urandom_range(0, 31));
			req.src_y = COORD_BITS'($urandom_range(0, 31));
			send_request(req);
		end
	endtask

	task automatic test_steady_stream();
		configure(256, 200, 17, 9, 3, 2, 0);
		calm = 1'b1;
		run_stream(50);
	endtask

	initial begin : result_sink
		int stall;
		stall = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 18);
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_writes
		out_item_t want_w;
		if (arst_n && push && full)
			stall_cycles++;
		if (arst_n && pop && !empty) begin
			if (pending_writes.size() == 0) begin
				errors++;
				if (errors <= MAX_PRINT)
					$display("%0t: write x=%0d y=%0d color=%h last=%b, expected none", $time,
						result.dst_x, result.dst_y, result.color, result.last);
			end else begin
				want_w = pending_writes.pop_front();
				n_checked++;
				if (result.dst_x !== want_w.dst_x)
					flag_field("dst_x", 32'(want_w.dst_x), 32'(result.dst_x));
				if (result.dst_y !== want_w.dst_y)
					flag_field("dst_y", 32'(want_w.dst_y), 32'(result.dst_y));
				if (result.color !== want_w.color)
					flag_field("color", 32'(want_w.color), 32'(result.color));
				if (result.last !== want_w.last)
					flag_field("last", 32'(want_w.last), 32'(result.last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		canvas_cfg = '{width_px: 11'd128, height_px: 11'd128, offset_x: 10'd0,
			offset_y: 10'd0, scale_x: 4'd1, scale_y: 4'd1, byte_swap: 1'b0};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_palette_and_clipping();
		test_config_extremes();
		test_random_settings();
		test_result_backpressure();
		test_steady_stream();
		settle();
		errors += pending_writes.size();
		$display("run covered %0d requests (%0d draws) over many canvas settings, %0d writes checked",
			n_requests, n_draws, n_checked);
		$display("request side was held off for %0d cycles by a full block", stall_cycles);
		if (errors == 0) begin
			$display("tb_indexed_pixel_scaled_blitter_core: clean");
		end else begin
			$display("tb_indexed_pixel_scaled_blitter_core: errors");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_indexed_pixel_scaled_blitter_core: errors");
		$finish;
	end

endmodule

// ===== files.f =====
sv/ipsb_pkg.sv
sv/ipsb_regs.sv
sv/ipsb_front.sv
sv/ipsb_queue.sv
sv/ipsb_back.sv
sv/indexed_pixel_scaled_blitter_core.sv
dv/tb_indexed_pixel_scaled_blitter_core.sv
